@@ sv/k_way_merge_min_select_unit_macros.svh @@
// ----------------------------------------------------------------------------
// k-way merge assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef K_WAY_MERGE_MIN_SELECT_UNIT_MACROS_SVH
`define K_WAY_MERGE_MIN_SELECT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define KWM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kwm assertion failed");
`define KWM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("kwm assertion failed");
`else
`define KWM_ASSERT(label, clk, rst_n, prop)
`define KWM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ sv/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg
// shared constants, control structs and sequencer states of the k-way merge
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int MAX_LANES = 8;
  localparam int LANE_W    = 3;
  localparam int NUM_W     = LANE_W + 1;
  localparam int CFG_W     = 4;
  localparam int KEY_W     = 32;
  localparam int TAG_W     = 32;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic                    en;
    logic                    mark_end;
    logic [LANE_W-1:0]       lane;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } head_wr_t;

  typedef struct packed {
    logic              en;
    logic [LANE_W-1:0] lane;
  } head_clr_t;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic                    found;
    logic [LANE_W-1:0]       lane;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } scan_res_t;

endpackage

@@ sv/kwm_head_store.sv @@
// ----------------------------------------------------------------------------
// kwm_head_store
// per-lane head record registers with loaded and exhausted flags
// ----------------------------------------------------------------------------
module kwm_head_store import kwm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  head_wr_t                wr_i,
  input  head_clr_t               clr_i,
  input  logic [LANE_W-1:0]       rd_idx_i,
  output logic signed [KEY_W-1:0] rd_key_o,
  output logic [TAG_W-1:0]        rd_tag_o,
  output logic [MAX_LANES-1:0]    loaded_o,
  output logic [MAX_LANES-1:0]    exhausted_o
);

  logic signed [KEY_W-1:0] key_q [MAX_LANES];
  logic [TAG_W-1:0]        tag_q [MAX_LANES];
  logic [MAX_LANES-1:0]    loaded_d, loaded_q;
  logic [MAX_LANES-1:0]    exh_d, exh_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.mark_end) begin
      key_q[wr_i.lane] <= wr_i.key;
      tag_q[wr_i.lane] <= wr_i.tag;
    end
  end

  always_comb begin
    loaded_d = loaded_q;
    exh_d    = exh_q;
    if (clr_i.en) begin
      loaded_d[clr_i.lane] = 1'b0;
    end
    if (wr_i.en) begin
      if (wr_i.mark_end) begin
        exh_d[wr_i.lane] = 1'b1;
      end else begin
        loaded_d[wr_i.lane] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      exh_q    <= '0;
    end else begin
      loaded_q <= loaded_d;
      exh_q    <= exh_d;
    end
  end

  assign rd_key_o    = key_q[rd_idx_i];
  assign rd_tag_o    = tag_q[rd_idx_i];
  assign loaded_o    = loaded_q;
  assign exhausted_o = exh_q;

endmodule

@@ sv/kwm_min_scan.sv @@
// ----------------------------------------------------------------------------
// kwm_min_scan
// shared signed comparator keeping the least head seen during a lane scan
// ----------------------------------------------------------------------------
module kwm_min_scan import kwm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scan_ctl_t               ctl_i,
  input  logic [LANE_W-1:0]       idx_i,
  input  logic                    rd_loaded_i,
  input  logic signed [KEY_W-1:0] rd_key_i,
  input  logic [TAG_W-1:0]        rd_tag_i,
  output scan_res_t               res_o
);

  logic                    found_d, found_q;
  logic [LANE_W-1:0]       lane_d, lane_q;
  logic signed [KEY_W-1:0] key_d, key_q;
  logic [TAG_W-1:0]        tag_d, tag_q;
  logic                    take;

  // strict less keeps the lowest lane on ties
  assign take = ctl_i.step && rd_loaded_i && (!found_q || (rd_key_i < key_q));

  always_comb begin
    found_d = found_q;
    lane_d  = lane_q;
    key_d   = key_q;
    tag_d   = tag_q;
    if (ctl_i.start) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
      lane_d  = idx_i;
      key_d   = rd_key_i;
      tag_d   = rd_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    key_q  <= key_d;
    tag_q  <= tag_d;
  end

  assign res_o.found = found_q;
  assign res_o.lane  = lane_q;
  assign res_o.key   = key_q;
  assign res_o.tag   = tag_q;

endmodule

@@ sv/k_way_merge_min_select_unit.sv @@
// ----------------------------------------------------------------------------
// k_way_merge_min_select_unit
// k-way merge: picks the least-key lane head once all lanes in use are settled
// ----------------------------------------------------------------------------
//  channel   dir  handshake                payload
//  input     in   in_valid_i / in_ready_o  lane_i, in_key_i, in_tag_i, is_end_i
//  output    out  out_valid_o / out_ready_i out_key_o, out_tag_o, out_lane_o, last_o
//  config    in   cfg_we_i                 cfg_data_i (lanes in use)
//
//  a beat that leads to a selection passes accept, ready check, one comparator
//  step per lane in use and emit; a beat that leaves some lane empty passes
//  accept and ready check only; after the last result beats are just accepted
//  a single shared comparator scans the lane heads in turn
//  reset clears flags and sequencer at once, no clearing pass
//  the emit step waits while the output register holds an untaken beat
// ----------------------------------------------------------------------------
`include "k_way_merge_min_select_unit_macros.svh"

module k_way_merge_min_select_unit import kwm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [LANE_W-1:0]       lane_i,
  input  logic signed [KEY_W-1:0] in_key_i,
  input  logic [TAG_W-1:0]        in_tag_i,
  input  logic                    is_end_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [KEY_W-1:0] out_key_o,
  output logic [TAG_W-1:0]        out_tag_o,
  output logic [LANE_W-1:0]       out_lane_o,
  output logic                    last_o
);

  state_e                  state_d, state_q;
  logic [CFG_W-1:0]        cfg_q;
  logic [NUM_W-1:0]        n_eff;
  logic [LANE_W-1:0]       last_idx;
  logic [LANE_W-1:0]       idx_d, idx_q;
  logic                    done_d, done_q;
  logic                    out_valid_d, out_valid_q;
  logic                    out_load;
  logic signed [KEY_W-1:0] out_key_q;
  logic [TAG_W-1:0]        out_tag_q;
  logic [LANE_W-1:0]       out_lane_q;
  logic                    last_q;
  logic                    lane_ok;
  logic                    all_ready;

  head_wr_t                wr;
  head_clr_t               clr;
  scan_ctl_t               scan_ctl;
  scan_res_t               scan_res;
  logic signed [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0]        rd_tag;
  logic [MAX_LANES-1:0]    loaded;
  logic [MAX_LANES-1:0]    exhausted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_W'(MAX_LANES);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = NUM_W'(1);
    end else if (cfg_q > CFG_W'(MAX_LANES)) begin
      n_eff = NUM_W'(MAX_LANES);
    end else begin
      n_eff = NUM_W'(cfg_q);
    end
  end

  assign last_idx = LANE_W'(n_eff - NUM_W'(1));
  assign lane_ok  = {1'b0, lane_i} < n_eff;

  always_comb begin
    all_ready = 1'b1;
    for (int i = 0; i < MAX_LANES; i++) begin
      if ((NUM_W'(i) < n_eff) && !loaded[i] && !exhausted[i]) begin
        all_ready = 1'b0;
      end
    end
  end

  kwm_head_store u_head_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .clr_i       (clr),
    .rd_idx_i    (idx_q),
    .rd_key_o    (rd_key),
    .rd_tag_o    (rd_tag),
    .loaded_o    (loaded),
    .exhausted_o (exhausted)
  );

  kwm_min_scan u_min_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .idx_i       (idx_q),
    .rd_loaded_i (loaded[idx_q]),
    .rd_key_i    (rd_key),
    .rd_tag_i    (rd_tag),
    .res_o       (scan_res)
  );

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    done_d         = done_q;
    in_ready_o     = 1'b0;
    out_load       = 1'b0;
    wr.en          = 1'b0;
    wr.mark_end    = is_end_i;
    wr.lane        = lane_i;
    wr.key         = in_key_i;
    wr.tag         = in_tag_i;
    clr.en         = 1'b0;
    clr.lane       = scan_res.lane;
    scan_ctl.start = 1'b0;
    scan_ctl.step  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !done_q) begin
          wr.en   = lane_ok && !loaded[lane_i] && !exhausted[lane_i];
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (all_ready) begin
          scan_ctl.start = 1'b1;
          idx_d          = '0;
          state_d        = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        scan_ctl.step = 1'b1;
        idx_d         = idx_q + LANE_W'(1);
        if (idx_q == last_idx) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (scan_res.found) begin
            clr.en = 1'b1;
          end else begin
            done_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (scan_res.found) begin
        out_key_q  <= scan_res.key;
        out_tag_q  <= scan_res.tag;
        out_lane_q <= scan_res.lane;
        last_q     <= 1'b0;
      end else begin
        out_key_q  <= '0;
        out_tag_q  <= '0;
        out_lane_q <= '0;
        last_q     <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_tag_o   = out_tag_q;
  assign out_lane_o  = out_lane_q;
  assign last_o      = last_q;

  `KWM_ASSERT(a_flags_disjoint, clk_i, rst_ni, (loaded & exhausted) == '0)
  `KWM_ASSERT(a_done_sticky, clk_i, rst_ni, done_q |=> done_q)
  `KWM_ASSERT(a_winner_loaded, clk_i, rst_ni, clr.en |-> loaded[clr.lane])
  `KWM_ASSERT(a_last_done, clk_i, rst_ni, (out_valid_o && last_o) |-> done_q)
  `KWM_ASSERT(a_scan_in_range, clk_i, rst_ni, (state_q == ST_SCAN) |-> ({1'b0, idx_q} < n_eff))

endmodule
